// ===== sv/text_mode_console_writer_assert.svh =====
// Assertion macros for the text mode console writer.
// Used by the top level; the enclosing module must provide clk and rst_n.
`ifndef TEXT_MODE_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_MODE_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TMCW_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console writer check failed");

// Next-cycle implication, disabled while in reset.
`define TMCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console writer check failed");

`endif

// ===== sv/tmcw_pkg.sv =====
// Shared types and constants for the text mode console writer.
// Used by tmcw_screen_mem and text_mode_console_writer; depends on nothing.
`default_nettype none

package tmcw_pkg;

    // Screen geometry.
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_SPACES = 4;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;
    localparam int CHAR_W = 8;
    localparam int COLR_W = 4;
    localparam int TAB_W  = $clog2(TAB_SPACES + 1);

    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(CELL_COUNT - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);

    // Character codes with special meaning.
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;

    // Configuration registers.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACK_COLOUR = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORE_COLOUR = 1'b1;
    localparam logic [COLR_W-1:0] BACK_RESET = 4'h0;
    localparam logic [COLR_W-1:0] FORE_RESET = 4'hF;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_SETCUR = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [7:0] {
        ST_INIT   = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_PUT    = 8'b0000_0100,
        ST_SCRL   = 8'b0000_1000,
        ST_SDRAIN = 8'b0001_0000,
        ST_FILL   = 8'b0010_0000,
        ST_READ   = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  new_column;
        logic [ROW_W-1:0]  new_row;
        logic [IDX_W-1:0]  cell_index;
    } req_item_t;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
        logic [CELL_W-1:0] cell_data;
        logic              did_scroll;
    } rsp_item_t;

    // Port request to the screen memory.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CELL_W-1:0] wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

endpackage

`default_nettype wire

// ===== sv/tmcw_screen_mem.sv =====
// Screen cell memory: one write port and one registered read port.
// Depends on tmcw_pkg.
`default_nettype none

module tmcw_screen_mem (
    input  logic                          clk,
    input  tmcw_pkg::mem_req_t            mem_req,
    output logic [tmcw_pkg::CELL_W-1:0]   rd_data
);

    logic [tmcw_pkg::CELL_W-1:0] cells [tmcw_pkg::CELL_COUNT];
    logic [tmcw_pkg::CELL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            cells[mem_req.wr_addr] <= mem_req.wr_data;
        end
        rd_data_reg <= cells[mem_req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/text_mode_console_writer.sv =====
// A tab makes four character writes. A scroll copies each cell from the row below (1920 copies,
// the last one a drain write) and then blanks the bottom row with 80 writes; a clear blanks all
// 2000 cells through the single write port.
// Throughput: one request at a time; the next is taken once the sequencer is back in idle, which
// it reaches as the result enters the output register; that waits while an earlier result is stalled.
// Reset: cursor homes, colors go to back 0 / fore 15, and a pass zeroes all 2000 cells of the screen.
`default_nettype none
`include "text_mode_console_writer_assert.svh"

module text_mode_console_writer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  tmcw_pkg::req_item_t                 req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output tmcw_pkg::rsp_item_t                 rsp_data,
    input  logic                                cfg_write_en,
    input  logic [tmcw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tmcw_pkg::COLR_W-1:0]         cfg_data
);

    // Sequencer state and the shared sweep address counter.
    tmcw_pkg::state_t state_reg, state_next;
    logic [tmcw_pkg::ADDR_W-1:0] addr_reg, addr_next;

    // Cursor position.
    logic [tmcw_pkg::COL_W-1:0] cur_x_reg, cur_x_next;
    logic [tmcw_pkg::ROW_W-1:0] cur_y_reg, cur_y_next;

    // Remaining character writes for the current request (a tab needs several).
    logic [tmcw_pkg::TAB_W-1:0] puts_left_reg, puts_left_next;
    logic scrolled_reg, scrolled_next;

    // Character being written and the data captured by a cell read.
    logic [tmcw_pkg::CHAR_W-1:0] char_reg, char_next;
    logic [tmcw_pkg::CELL_W-1:0] data_reg, data_next;

    // Scroll copy pipeline: a read issued last cycle lands at cp_addr_reg this cycle.
    logic cp_valid_reg, cp_valid_next;
    logic [tmcw_pkg::ADDR_W-1:0] cp_addr_reg, cp_addr_next;

    // Color registers.
    logic [tmcw_pkg::COLR_W-1:0] back_reg;
    logic [tmcw_pkg::COLR_W-1:0] fore_reg;

    // Output register.
    logic rsp_valid_reg, rsp_valid_next;
    tmcw_pkg::rsp_item_t rsp_data_reg, rsp_data_next;

    tmcw_pkg::mem_req_t mem_req;
    logic [tmcw_pkg::CELL_W-1:0] rd_data;

    logic [tmcw_pkg::CELL_W-1:0] blank_cell;
    logic [tmcw_pkg::ADDR_W-1:0] cur_addr;
    logic [tmcw_pkg::ADDR_W-1:0] addr_inc;
    logic [tmcw_pkg::COL_W:0]    x_inc;

    // Conditions watched by the checks at the end.
    logic cursor_on_screen;
    logic in_copy;
    logic in_sweep;

    tmcw_screen_mem u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    assign blank_cell = {back_reg, fore_reg, tmcw_pkg::CHAR_BLANK};
    assign cur_addr   = tmcw_pkg::ADDR_W'(32'(cur_y_reg) * tmcw_pkg::COLUMNS
                                          + 32'(cur_x_reg));
    assign addr_inc   = addr_reg + tmcw_pkg::ADDR_W'(1);
    assign x_inc      = {1'b0, cur_x_reg} + (tmcw_pkg::COL_W + 1)'(1);

    // The block takes a request only when the sequencer rests in idle. A finished
    // result may still sit in the output register at that time.
    assign req_stall = (state_reg != tmcw_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        puts_left_next = puts_left_reg;
        scrolled_next  = scrolled_reg;
        char_next      = char_reg;
        data_next      = data_reg;
        cp_valid_next  = 1'b0;
        cp_addr_next   = cp_addr_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_data_next  = rsp_data_reg;

        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = addr_reg;
        mem_req.wr_data = '0;
        mem_req.rd_addr = '0;

        case (state_reg)
            tmcw_pkg::ST_INIT:
            begin
                // Clearing pass after reset: every cell becomes zero.
                mem_req.wr_en = 1'b1;
                if (addr_reg == tmcw_pkg::LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = tmcw_pkg::ST_IDLE;
                end
                else
                begin
                    addr_next = addr_inc;
                end
            end

            tmcw_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    scrolled_next = 1'b0;
                    data_next     = '0;
                    addr_next     = '0;
                    state_next    = tmcw_pkg::ST_DONE;
                    case (req_data.opcode)
                        tmcw_pkg::OP_PUT:
                        begin
                            if (req_data.char_code == tmcw_pkg::CHAR_NL)
                            begin
                                // Newline on the last row scrolls; the cursor stays there.
                                cur_x_next = '0;
                                if (32'(cur_y_reg) == tmcw_pkg::ROWS - 1)
                                begin
                                    scrolled_next  = 1'b1;
                                    puts_left_next = '0;
                                    state_next     = tmcw_pkg::ST_SCRL;
                                end
                                else
                                begin
                                    cur_y_next = cur_y_reg + tmcw_pkg::ROW_W'(1);
                                end
                            end
                            else if (req_data.char_code == tmcw_pkg::CHAR_TAB)
                            begin
                                char_next      = tmcw_pkg::CHAR_BLANK;
                                puts_left_next = tmcw_pkg::TAB_W'(tmcw_pkg::TAB_SPACES);
                                state_next     = tmcw_pkg::ST_PUT;
                            end
                            else if (req_data.char_code != tmcw_pkg::CHAR_NUL)
                            begin
                                char_next      = req_data.char_code;
                                puts_left_next = tmcw_pkg::TAB_W'(1);
                                state_next     = tmcw_pkg::ST_PUT;
                            end
                        end

                        tmcw_pkg::OP_CLEAR:
                        begin
                            cur_x_next     = '0;
                            cur_y_next     = '0;
                            puts_left_next = '0;
                            state_next     = tmcw_pkg::ST_FILL;
                        end

                        tmcw_pkg::OP_SETCUR:
                        begin
                            // Positions past the edge saturate to the last column or row.
                            if (32'(req_data.new_column) >= tmcw_pkg::COLUMNS)
                            begin
                                cur_x_next = tmcw_pkg::COL_W'(tmcw_pkg::COLUMNS - 1);
                            end
                            else
                            begin
                                cur_x_next = req_data.new_column;
                            end
                            if (32'(req_data.new_row) >= tmcw_pkg::ROWS)
                            begin
                                cur_y_next = tmcw_pkg::ROW_W'(tmcw_pkg::ROWS - 1);
                            end
                            else
                            begin
                                cur_y_next = req_data.new_row;
                            end
                        end

                        tmcw_pkg::OP_READ:
                        begin
                            // Reads beyond the screen return zero without touching memory.
                            if (32'(req_data.cell_index) < tmcw_pkg::CELL_COUNT)
                            begin
                                mem_req.rd_addr = tmcw_pkg::ADDR_W'(req_data.cell_index);
                                state_next      = tmcw_pkg::ST_READ;
                            end
                        end

                        default:
                        begin
                            state_next = tmcw_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            tmcw_pkg::ST_PUT:
            begin
                // Write one character at the cursor, then advance with wrap and scroll.
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cur_addr;
                mem_req.wr_data = {back_reg, fore_reg, char_reg};
                puts_left_next  = puts_left_reg - tmcw_pkg::TAB_W'(1);
                addr_next       = '0;
                if (32'(x_inc) >= tmcw_pkg::COLUMNS)
                begin
                    cur_x_next = '0;
                    if (32'(cur_y_reg) == tmcw_pkg::ROWS - 1)
                    begin
                        scrolled_next = 1'b1;
                        state_next    = tmcw_pkg::ST_SCRL;
                    end
                    else
                    begin
                        cur_y_next = cur_y_reg + tmcw_pkg::ROW_W'(1);
                        if (puts_left_reg == tmcw_pkg::TAB_W'(1))
                        begin
                            state_next = tmcw_pkg::ST_DONE;
                        end
                    end
                end
                else
                begin
                    cur_x_next = x_inc[tmcw_pkg::COL_W-1:0];
                    if (puts_left_reg == tmcw_pkg::TAB_W'(1))
                    begin
                        state_next = tmcw_pkg::ST_DONE;
                    end
                end
            end

            tmcw_pkg::ST_SCRL:
            begin
                // Copy each cell from one row below; each write comes in the cycle after its read.
                mem_req.rd_addr = addr_reg + tmcw_pkg::ROW_STRIDE;
                cp_valid_next   = 1'b1;
                cp_addr_next    = addr_reg;
                if (cp_valid_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = cp_addr_reg;
                    mem_req.wr_data = rd_data;
                end
                addr_next = addr_inc;
                if (addr_reg == tmcw_pkg::COPY_LAST)
                begin
                    state_next = tmcw_pkg::ST_SDRAIN;
                end
            end

            tmcw_pkg::ST_SDRAIN:
            begin
                // Last copy write; the bottom row is blanked next.
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cp_addr_reg;
                mem_req.wr_data = rd_data;
                state_next      = tmcw_pkg::ST_FILL;
            end

            tmcw_pkg::ST_FILL:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_data = blank_cell;
                if (addr_reg == tmcw_pkg::LAST_ADDR)
                begin
                    addr_next = '0;
                    if (puts_left_reg == '0)
                    begin
                        state_next = tmcw_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = tmcw_pkg::ST_PUT;
                    end
                end
                else
                begin
                    addr_next = addr_inc;
                end
            end

            tmcw_pkg::ST_READ:
            begin
                data_next  = rd_data;
                state_next = tmcw_pkg::ST_DONE;
            end

            tmcw_pkg::ST_DONE:
            begin
                // Hand the result over once the output register is free.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next              = 1'b1;
                    rsp_data_next.cursor_column = cur_x_reg;
                    rsp_data_next.cursor_row    = cur_y_reg;
                    rsp_data_next.cell_data     = data_reg;
                    rsp_data_next.did_scroll    = scrolled_reg;
                    state_next                  = tmcw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tmcw_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tmcw_pkg::ST_INIT;
            addr_reg      <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            puts_left_reg <= '0;
            scrolled_reg  <= 1'b0;
            cp_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            puts_left_reg <= puts_left_next;
            scrolled_reg  <= scrolled_next;
            cp_valid_reg  <= cp_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        char_reg     <= char_next;
        data_reg     <= data_next;
        cp_addr_reg  <= cp_addr_next;
        rsp_data_reg <= rsp_data_next;
    end

    // Color registers; the user must write the configuration only while no request is in flight (unenforced).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            back_reg <= tmcw_pkg::BACK_RESET;
            fore_reg <= tmcw_pkg::FORE_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                tmcw_pkg::CFG_BACK_COLOUR: back_reg <= cfg_data;
                tmcw_pkg::CFG_FORE_COLOUR: fore_reg <= cfg_data;
                default:
                begin
                    back_reg <= back_reg;
                end
            endcase
        end
    end

    assign cursor_on_screen = (32'(cur_x_reg) < tmcw_pkg::COLUMNS)
                              && (32'(cur_y_reg) < tmcw_pkg::ROWS);
    assign in_copy          = (state_reg == tmcw_pkg::ST_SCRL)
                              || (state_reg == tmcw_pkg::ST_SDRAIN);
    assign in_sweep         = (state_reg == tmcw_pkg::ST_INIT)
                              || (state_reg == tmcw_pkg::ST_FILL);

    // The cursor never leaves the screen.
    `TMCW_ASSERT_IMPLIES(a_cursor_range, 1'b1, cursor_on_screen)
    // An accepted request keeps the block busy in the following cycle.
    `TMCW_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
    // A pending copy write exists only inside the scroll sweep.
    `TMCW_ASSERT_IMPLIES(a_copy_in_scroll, cp_valid_reg, in_copy)
    // Sweeps stay inside the screen memory.
    `TMCW_ASSERT_IMPLIES(a_sweep_range, in_sweep, addr_reg <= tmcw_pkg::LAST_ADDR)

endmodule

`default_nettype wire
